FILE: rtl/core/cnam_pkg.sv
package cnam_pkg;

   localparam int DEFAULT_NUM_NODES   = 16;
   localparam int DEFAULT_NUM_SIGNALS = 1024;

   localparam int MODE_W     = 2;
   localparam int SIG_W      = 10;
   localparam int NODE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int MV_W       = 16;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RECV  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_VOLTAGE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_VOLTAGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_TIME = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_TIME = 2'd3;

   localparam logic [MV_W-1:0]   RESET_LOW_MV     = 16'd9000;
   localparam logic [MV_W-1:0]   RESET_HIGH_MV    = 16'd16000;
   localparam logic [TIME_W-1:0] RESET_CONFIRM_MS = 32'd1000;
   localparam logic [TIME_W-1:0] RESET_RECOVER_MS = 32'd100;

   localparam logic [NODE_W-1:0] UNMAPPED_NODE = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_LOOKUP,
      ST_STAMP,
      ST_PRIME,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/cnam_signal_map.sv
module cnam_signal_map #(
   parameter int NUM_SIGNALS = cnam_pkg::DEFAULT_NUM_SIGNALS,
   parameter int ADDR_W      = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [cnam_pkg::NODE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [cnam_pkg::NODE_W-1:0] rd_data
);
   import cnam_pkg::*;

   logic [NODE_W-1:0] map_mem [NUM_SIGNALS];
   logic [NODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/can_node_absence_monitor_unit.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  mode, signal_index, node_number, now_ms,
//                                          supply_mv, bus_flag
// rsp      out        rsp_valid/rsp_stall  miss_mask, gate_open
// csr      in         csr_wr_en            csr_index, csr_wr_data
//
// After reset the signal map is cleared one entry per cycle; no transaction is
// accepted until it completes. A map transaction runs ST_MAP then ST_DONE, a receive
// transaction ST_LOOKUP, ST_STAMP, ST_DONE, and a check transaction ST_PRIME, ST_WALK,
// ST_DONE, with the single age subtractor and comparator visiting one node per cycle.
// The result sits in an output register, so a new transaction may be accepted while a
// previous result is stalled; the block then holds in its final state until that is taken.
module can_node_absence_monitor_unit #(
   parameter int NUM_NODES   = cnam_pkg::DEFAULT_NUM_NODES,
   parameter int NUM_SIGNALS = cnam_pkg::DEFAULT_NUM_SIGNALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cnam_pkg::MODE_W-1:0]     req_mode,
   input  logic [cnam_pkg::SIG_W-1:0]      req_signal_index,
   input  logic [cnam_pkg::NODE_W-1:0]     req_node_number,
   input  logic [cnam_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [cnam_pkg::MV_W-1:0]       req_supply_mv,
   input  logic                            req_bus_flag,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cnam_pkg::MASK_W-1:0]     rsp_miss_mask,
   output logic                            rsp_gate_open,
   input  logic                            csr_wr_en,
   input  logic [cnam_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cnam_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import cnam_pkg::*;

   localparam int SIG_AW  = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
   localparam int NODE_AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
   localparam logic [SIG_AW-1:0]  LAST_SIG  = SIG_AW'(NUM_SIGNALS - 1);
   localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(NUM_NODES - 1);

   state_type state_ff, state_in;

   logic [MV_W-1:0]   low_mv_ff, low_mv_in;
   logic [MV_W-1:0]   high_mv_ff, high_mv_in;
   logic [TIME_W-1:0] confirm_ff, confirm_in;
   logic [TIME_W-1:0] recover_ff, recover_in;

   logic [SIG_W-1:0]  sig_ff;
   logic              sig_ok_ff;
   logic [NODE_W-1:0] node_ff;
   logic [TIME_W-1:0] now_ff;
   logic              gate_ff;

   logic [SIG_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [NODE_AW-1:0] cnt_ff, cnt_in;
   logic [NUM_NODES-1:0] flags_ff, flags_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_gate_ff;
   logic [MASK_W-1:0] mask_view;

   logic               req_take;
   logic               out_load;
   logic               map_we;
   logic [SIG_AW-1:0]  map_waddr;
   logic [NODE_W-1:0]  map_wdata;
   logic [SIG_AW-1:0]  map_raddr;
   logic [NODE_W-1:0]  map_rdata;
   logic               node_ok;

   logic [TIME_W-1:0]  seen_mem [NUM_NODES];
   logic [NUM_NODES-1:0] seen_vld_ff;
   logic               seen_we;
   logic [NODE_AW-1:0] seen_waddr;
   logic [NODE_AW-1:0] seen_raddr;
   logic [TIME_W-1:0]  seen_rd_ff;
   logic               seen_rd_vld_ff;

   logic [TIME_W-1:0]  seen_val;
   logic [TIME_W-1:0]  age;
   logic [TIME_W-1:0]  cmp_a;
   logic [TIME_W-1:0]  cmp_b;
   logic               cmp_hit;
   logic               cur_flag;

   cnam_signal_map #(
      .NUM_SIGNALS (NUM_SIGNALS),
      .ADDR_W      (SIG_AW)
   ) u_signal_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign node_ok   = (32'(map_rdata) < 32'(NUM_NODES));

   // The shared unit: one age subtraction and one magnitude compare per node.
   assign seen_val = seen_rd_vld_ff ? seen_rd_ff : '0;
   assign age      = now_ff - seen_val;
   assign cur_flag = flags_ff[cnt_ff];
   assign cmp_a    = cur_flag ? recover_ff : age;
   assign cmp_b    = cur_flag ? age : confirm_ff;
   assign cmp_hit  = (cmp_a > cmp_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_SIG) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_MAP:   state_in = ST_MAP;
                  MODE_RECV:  state_in = ST_LOOKUP;
                  MODE_CHECK: state_in = ST_PRIME;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_MAP:    state_in = ST_DONE;
         ST_LOOKUP: state_in = ST_STAMP;
         ST_STAMP:  state_in = ST_DONE;
         ST_PRIME:  state_in = ST_WALK;
         ST_WALK: begin
            if (cnt_ff == LAST_NODE) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      map_we     = 1'b0;
      map_waddr  = SIG_AW'(sig_ff);
      map_wdata  = node_ff;
      map_raddr  = SIG_AW'(sig_ff);
      seen_we    = 1'b0;
      seen_waddr = cnt_ff;
      seen_raddr = cnt_ff + 1'b1;
      clr_cnt_in = clr_cnt_ff;
      cnt_in     = cnt_ff;
      flags_in   = flags_ff;
      case (state_ff)
         ST_CLEAR: begin
            map_we     = 1'b1;
            map_waddr  = clr_cnt_ff;
            map_wdata  = UNMAPPED_NODE;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_MAP: begin
            map_we = sig_ok_ff;
         end
         ST_STAMP: begin
            seen_we    = sig_ok_ff && node_ok;
            seen_waddr = NODE_AW'(map_rdata);
         end
         ST_PRIME: begin
            seen_raddr = '0;
            cnt_in     = '0;
         end
         ST_WALK: begin
            cnt_in = cnt_ff + 1'b1;
            if (gate_ff) begin
               flags_in[cnt_ff] = cur_flag ? !cmp_hit : cmp_hit;
            end else begin
               seen_we          = 1'b1;
               flags_in[cnt_ff] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      low_mv_in  = low_mv_ff;
      high_mv_in = high_mv_ff;
      confirm_in = confirm_ff;
      recover_in = recover_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_VOLTAGE:  low_mv_in  = csr_wr_data[MV_W-1:0];
            CSR_HIGH_VOLTAGE: high_mv_in = csr_wr_data[MV_W-1:0];
            CSR_CONFIRM_TIME: confirm_in = csr_wr_data[TIME_W-1:0];
            CSR_RECOVER_TIME: recover_in = csr_wr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < NUM_NODES) begin : g_node
         assign mask_view[i] = flags_ff[i];
      end else begin : g_pad
         assign mask_view[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         low_mv_ff    <= RESET_LOW_MV;
         high_mv_ff   <= RESET_HIGH_MV;
         confirm_ff   <= RESET_CONFIRM_MS;
         recover_ff   <= RESET_RECOVER_MS;
         clr_cnt_ff   <= '0;
         cnt_ff       <= '0;
         flags_ff     <= '0;
         seen_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_mv_ff    <= low_mv_in;
         high_mv_ff   <= high_mv_in;
         confirm_ff   <= confirm_in;
         recover_ff   <= recover_in;
         clr_cnt_ff   <= clr_cnt_in;
         cnt_ff       <= cnt_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         if (seen_we) begin
            seen_vld_ff[seen_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sig_ff    <= req_signal_index;
         sig_ok_ff <= (32'(req_signal_index) < 32'(NUM_SIGNALS));
         node_ff   <= req_node_number;
         now_ff    <= req_now_ms;
         gate_ff   <= (req_mode == MODE_CHECK) && req_bus_flag &&
                      (req_supply_mv >= low_mv_ff) && (req_supply_mv <= high_mv_ff);
      end
      if (out_load) begin
         rsp_mask_ff <= mask_view;
         rsp_gate_ff <= gate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= now_ff;
      end
      seen_rd_ff     <= seen_mem[seen_raddr];
      seen_rd_vld_ff <= seen_vld_ff[seen_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_miss_mask = rsp_mask_ff;
   assign rsp_gate_open = rsp_gate_ff;

endmodule
